// ----- src/rgb_to_hsv_converter_core_macros.svh -----
// Assertion macros shared by the RGB to HSV converter RTL.
// No dependencies; included by the top level only.
`ifndef RGB_TO_HSV_CONVERTER_CORE_MACROS_SVH
`define RGB_TO_HSV_CONVERTER_CORE_MACROS_SVH

// Implication check, sampled on the rising clock edge, off during reset
`define HSVC_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Condition that must never be seen outside reset
`define HSVC_ASSERT_NEVER(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error(msg);

`endif

// ----- src/hsvc_pkg.sv -----
// Shared types and constants of the RGB to HSV converter pipeline.
// No dependencies; imported by every module of the block.
`default_nettype none

package hsvc_pkg;

    // Hue geometry in whole degrees
    localparam logic [8:0] DEG_FULL    = 9'd360;
    localparam logic [8:0] GREEN_BASE  = 9'd120;
    localparam logic [8:0] BLUE_BASE   = 9'd240;

    // Degrees to 16-bit hue: floor(deg * 65536 / 360) == (deg * HUE_RECIP) >> HUE_SHIFT
    // for every deg below 360 (rounded-up reciprocal, error stays below 1/45).
    localparam int unsigned HUE_SHIFT = 14;
    localparam longint unsigned HUE_NUM = 64'd65536 << HUE_SHIFT;
    localparam logic [21:0] HUE_RECIP = 22'((HUE_NUM + 64'd359) / 64'd360);

    // Which channel holds the maximum
    typedef enum logic [1:0] {
        SECT_RED,
        SECT_GREEN,
        SECT_BLUE
    } hsvc_sector_t;

    // First-stage results: extremes and the signed channel difference
    typedef struct packed {
        logic [7:0]   mx;
        logic [7:0]   d;
        logic [7:0]   mag;
        logic         neg;
        hsvc_sector_t sector;
    } hsvc_pix_t;

    // Long division in flight: partial remainder, dividend bits still to
    // bring down (MSB first) and quotient bits so far
    typedef struct packed {
        logic [7:0] rem;
        logic [7:0] low;
        logic [7:0] quo;
    } hsvc_div_t;

    // Payload carried through the divider stages
    typedef struct packed {
        hsvc_div_t    hue;
        hsvc_div_t    sat;
        logic [7:0]   d;
        logic [7:0]   mx;
        logic         neg;
        logic         gray;
        hsvc_sector_t sector;
    } hsvc_work_t;

    // Hue in degrees plus finished saturation and value
    typedef struct packed {
        logic [8:0] deg;
        logic [7:0] sat;
        logic [7:0] val;
    } hsvc_deg_t;

endpackage

`default_nettype wire

// ----- src/hsvc_front.sv -----
// Front end: max/min, hue sector and divider operand setup (two stages).
// Depends on hsvc_pkg.
`default_nettype none

module hsvc_front (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire logic [7:0]         red_in,
    input  wire logic [7:0]         green_in,
    input  wire logic [7:0]         blue_in,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output hsvc_pkg::hsvc_work_t    out_data
);
    import hsvc_pkg::*;

    logic       s1_valid_reg;
    logic       s1_ready;
    hsvc_pix_t  s1_reg;
    hsvc_pix_t  s1_next;
    logic       s2_valid_reg;
    hsvc_work_t s2_reg;
    hsvc_work_t s2_next;

    logic [7:0]  mx;
    logic [7:0]  mn;
    logic [7:0]  dif_p;
    logic [7:0]  dif_q;
    logic [15:0] hue_dvd;
    logic [15:0] sat_dvd;

    // Stage 1: extremes, winning channel (blue over green over red), |x|
    always_comb begin
        mx = red_in;
        mn = red_in;
        if (green_in > mx) mx = green_in;
        if (blue_in > mx) mx = blue_in;
        if (green_in < mn) mn = green_in;
        if (blue_in < mn) mn = blue_in;

        if (blue_in == mx) begin
            s1_next.sector = SECT_BLUE;
            dif_p = red_in;
            dif_q = green_in;
        end else if (green_in == mx) begin
            s1_next.sector = SECT_GREEN;
            dif_p = blue_in;
            dif_q = red_in;
        end else begin
            s1_next.sector = SECT_RED;
            dif_p = green_in;
            dif_q = blue_in;
        end

        s1_next.mx  = mx;
        s1_next.d   = mx - mn;
        s1_next.neg = dif_p < dif_q;
        s1_next.mag = (dif_p < dif_q) ? (dif_q - dif_p) : (dif_p - dif_q);
    end

    assign in_ready = !s1_valid_reg || s1_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (in_ready) begin
            s1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            s1_reg <= s1_next;
        end
    end

    // Stage 2: dividends 60*|x| and 255*d, top byte preloaded as remainder
    always_comb begin
        hue_dvd = {2'b00, s1_reg.mag, 6'b0} - {6'b0, s1_reg.mag, 2'b0};
        sat_dvd = {s1_reg.d, 8'b0} - {8'b0, s1_reg.d};

        s2_next.hue.rem = hue_dvd[15:8];
        s2_next.hue.low = hue_dvd[7:0];
        s2_next.hue.quo = 8'd0;
        s2_next.sat.rem = sat_dvd[15:8];
        s2_next.sat.low = sat_dvd[7:0];
        s2_next.sat.quo = 8'd0;
        s2_next.d       = s1_reg.d;
        s2_next.mx      = s1_reg.mx;
        s2_next.neg     = s1_reg.neg;
        s2_next.gray    = s1_reg.d == 8'd0;
        s2_next.sector  = s1_reg.sector;
    end

    assign s1_ready = !s2_valid_reg || out_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s2_valid_reg <= 1'b0;
        end else if (s1_ready) begin
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (s1_ready && s1_valid_reg) begin
            s2_reg <= s2_next;
        end
    end

    assign out_valid = s2_valid_reg;
    assign out_data  = s2_reg;

endmodule

`default_nettype wire

// ----- src/hsvc_div_stage.sv -----
// One divider stage: two restoring long-division steps for hue and saturation.
// Depends on hsvc_pkg.
`default_nettype none

module hsvc_div_stage (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  in_valid,
    output logic                       in_ready,
    input  wire hsvc_pkg::hsvc_work_t  in_data,
    output logic                       out_valid,
    input  wire logic                  out_ready,
    output hsvc_pkg::hsvc_work_t       out_data
);
    import hsvc_pkg::*;

    logic       valid_reg;
    hsvc_work_t data_reg;
    hsvc_work_t data_next;

    // Bring down one dividend bit, subtract the divisor if it fits.
    // Remainder stays below the divisor, so 8 bits hold it.
    function automatic hsvc_div_t div_step(input hsvc_div_t cur, input logic [7:0] dvs);
        hsvc_div_t  nxt;
        logic [8:0] trial;
        logic       fits;
        trial    = {cur.rem, cur.low[7]};
        fits     = trial >= {1'b0, dvs};
        nxt.rem  = fits ? 8'(trial - {1'b0, dvs}) : trial[7:0];
        nxt.low  = {cur.low[6:0], 1'b0};
        nxt.quo  = {cur.quo[6:0], fits};
        return nxt;
    endfunction

    always_comb begin
        data_next     = in_data;
        data_next.hue = div_step(div_step(in_data.hue, in_data.d), in_data.d);
        data_next.sat = div_step(div_step(in_data.sat, in_data.mx), in_data.mx);
    end

    assign in_ready = !valid_reg || out_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

`default_nettype wire

// ----- src/hsvc_hue_out.sv -----
// Back end: hue quotient to degrees, then scaling to 16 bits (two stages).
// Depends on hsvc_pkg.
`default_nettype none

module hsvc_hue_out (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  in_valid,
    output logic                       in_ready,
    input  wire hsvc_pkg::hsvc_work_t  in_data,
    output logic                       out_valid,
    input  wire logic                  out_ready,
    output logic [15:0]                hue_out,
    output logic [7:0]                 sat_out,
    output logic [7:0]                 val_out
);
    import hsvc_pkg::*;

    logic       deg_valid_reg;
    logic       deg_ready;
    hsvc_deg_t  deg_reg;
    hsvc_deg_t  deg_next;
    logic       out_valid_reg;
    logic [30:0] prod_reg;
    logic [30:0] prod_next;
    logic [7:0]  sat_reg;
    logic [7:0]  val_reg;

    logic [8:0] q9;
    logic [8:0] rem_nz9;

    // Stage 1: sector offset; green and blue round toward minus infinity,
    // red truncates toward zero and wraps into the top of the circle
    always_comb begin
        q9      = {1'b0, in_data.hue.quo};
        rem_nz9 = {8'd0, in_data.hue.rem != 8'd0};
        case (in_data.sector)
            SECT_RED: begin
                if (!in_data.neg) deg_next.deg = q9;
                else if (q9 == 9'd0) deg_next.deg = 9'd0;
                else deg_next.deg = DEG_FULL - q9;
            end
            SECT_GREEN: begin
                deg_next.deg = in_data.neg ? (GREEN_BASE - q9 - rem_nz9) : (GREEN_BASE + q9);
            end
            SECT_BLUE: begin
                deg_next.deg = in_data.neg ? (BLUE_BASE - q9 - rem_nz9) : (BLUE_BASE + q9);
            end
            default: begin
                deg_next.deg = 9'd0;
            end
        endcase
        // Gray (and black) pixels: no hue, no saturation
        if (in_data.gray) deg_next.deg = 9'd0;
        deg_next.sat = in_data.gray ? 8'd0 : in_data.sat.quo;
        deg_next.val = in_data.mx;
    end

    assign in_ready = !deg_valid_reg || deg_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            deg_valid_reg <= 1'b0;
        end else if (in_ready) begin
            deg_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            deg_reg <= deg_next;
        end
    end

    // Stage 2: multiply by the rounded-up reciprocal of 360/65536
    assign prod_next = {22'd0, deg_reg.deg} * {9'd0, HUE_RECIP};
    assign deg_ready = !out_valid_reg || out_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (deg_ready) begin
            out_valid_reg <= deg_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (deg_ready && deg_valid_reg) begin
            prod_reg <= prod_next;
            sat_reg  <= deg_reg.sat;
            val_reg  <= deg_reg.val;
        end
    end

    assign out_valid = out_valid_reg;
    assign hue_out   = prod_reg[HUE_SHIFT+15:HUE_SHIFT];
    assign sat_out   = sat_reg;
    assign val_out   = val_reg;

endmodule

`default_nettype wire

// ----- src/rgb_to_hsv_converter_core.sv -----
// RGB to HSV converter, top level: front end, four divider stages, back end.
// Depends on hsvc_pkg, hsvc_front, hsvc_div_stage, hsvc_hue_out and the macro header.
//
// Converts one 8-bit RGB pixel per transfer into a 16-bit hue (degrees
// scaled by 65536/360, truncated) with 8-bit saturation and value. The block
// is a fully pipelined chain of eight register stages and takes a new
// pixel on every clock while the output is not stalled by back pressure.
// The two divisions (hue sector fraction and 255*(max-min)/max) run as
// restoring long division, two quotient bits per stage over four stages.
// Each stage holds its own valid bit and stalls only when the stage after it
// is full, so bubbles close up under back pressure and nothing is lost or
// repeated. Gray pixels give hue 0; black pixels give saturation 0.
`default_nettype none

`include "rgb_to_hsv_converter_core_macros.svh"

module rgb_to_hsv_converter_core (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [23:0] s_tdata,   // red_in[7:0], green_in[15:8], blue_in[23:16]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [31:0]      m_tdata    // hue_out[15:0], sat_out[23:16], val_out[31:24]
);
    import hsvc_pkg::*;

    localparam int unsigned DIV_STAGES = 4;

    logic       div_valid [0:DIV_STAGES];
    logic       div_ready [0:DIV_STAGES];
    hsvc_work_t work      [0:DIV_STAGES];

    logic [15:0] hue;
    logic [7:0]  sat;
    logic [7:0]  val;

    // Max/min and operand setup
    hsvc_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .red_in    (s_tdata[7:0]),
        .green_in  (s_tdata[15:8]),
        .blue_in   (s_tdata[23:16]),
        .out_valid (div_valid[0]),
        .out_ready (div_ready[0]),
        .out_data  (work[0])
    );

    // Division chain, eight quotient bits in all
    for (genvar i = 0; i < DIV_STAGES; i++) begin : g_div
        hsvc_div_stage u_div (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .in_valid  (div_valid[i]),
            .in_ready  (div_ready[i]),
            .in_data   (work[i]),
            .out_valid (div_valid[i+1]),
            .out_ready (div_ready[i+1]),
            .out_data  (work[i+1])
        );
    end

    // Degrees and hue scaling, output register
    hsvc_hue_out u_hue_out (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (div_valid[DIV_STAGES]),
        .in_ready  (div_ready[DIV_STAGES]),
        .in_data   (work[DIV_STAGES]),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .hue_out   (hue),
        .sat_out   (sat),
        .val_out   (val)
    );

    assign m_tdata = {val, sat, hue};

    // Checks
    `HSVC_ASSERT_NEVER(a_no_false_stall, aclk, aresetn, !m_tvalid && !s_tready, "input stalled with an empty output register")
    `HSVC_ASSERT_IMP(a_black_zero, aclk, aresetn, m_tvalid && (val == 8'd0), (sat == 8'd0) && (hue == 16'd0), "black pixel with nonzero hue or saturation")
    `HSVC_ASSERT_IMP(a_hue_quo_range, aclk, aresetn, div_valid[DIV_STAGES] && !work[DIV_STAGES].gray, work[DIV_STAGES].hue.quo <= 8'd60, "hue sector fraction above 60 degrees")
    `HSVC_ASSERT_IMP(a_hue_rem_range, aclk, aresetn, div_valid[DIV_STAGES] && !work[DIV_STAGES].gray, work[DIV_STAGES].hue.rem < work[DIV_STAGES].d, "hue remainder not below divisor")

endmodule

`default_nettype wire
